@@ src/sfpe_pkg.sv @@
// ----------------------------------------------------------------------------
// sfpe_pkg
// Shared types, codes and constants of the SENT frame pulse encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package sfpe_pkg;

	// frame geometry
	localparam int unsigned MAX_DATA_NIBBLES = 8;
	localparam logic [5:0] SYNC_TICKS = 6'd56;
	localparam logic [5:0] BASE_TICKS = 6'd12;
	localparam logic [5:0] END_TICKS = 6'd2;
	localparam logic [2:0] PULSE_TICKS = 3'd5;
	localparam logic [2:0] END_PULSE_TICKS = 3'd1;
	localparam logic [3:0] CRC_SEED = 4'h3;

	// configuration register indexes
	localparam logic [1:0] REG_NIBBLE_COUNT = 2'd0;
	localparam logic [1:0] REG_PAUSE_ENABLE = 2'd1;
	localparam logic [1:0] REG_IDLE_POLARITY = 2'd2;

	// period kinds as sent on segment_kind
	typedef enum logic [2:0] {
		KIND_SYNC   = 3'd0,
		KIND_STATUS = 3'd1,
		KIND_DATA   = 3'd2,
		KIND_CRC    = 3'd3,
		KIND_PAUSE  = 3'd4,
		KIND_END    = 3'd5
	} kind_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SYNC,
		ST_STATUS,
		ST_DATA,
		ST_CRC,
		ST_PAUSE,
		ST_END
	} state_t;

	// sequencer to datapath controls
	typedef struct packed {
		logic  load;
		logic  step;
		logic  emit;
		kind_t kind;
	} ctrl_t;

	// one crc4 step: table lookup on crc xor nibble
	function automatic logic [3:0] crc_step(input logic [3:0] crc, input logic [3:0] nib);
		logic [3:0] idx;
		logic [3:0] res;
		idx = crc ^ nib;
		case (idx)
			4'h0: res = 4'd0;
			4'h1: res = 4'd13;
			4'h2: res = 4'd7;
			4'h3: res = 4'd10;
			4'h4: res = 4'd14;
			4'h5: res = 4'd3;
			4'h6: res = 4'd9;
			4'h7: res = 4'd4;
			4'h8: res = 4'd1;
			4'h9: res = 4'd12;
			4'hA: res = 4'd6;
			4'hB: res = 4'd11;
			4'hC: res = 4'd15;
			4'hD: res = 4'd2;
			4'hE: res = 4'd8;
			default: res = 4'd5;
		endcase
		return res;
	endfunction

endpackage

`default_nettype wire

@@ src/sent_frame_pulse_encoder_unit.sv @@
// ----------------------------------------------------------------------------
// sent_frame_pulse_encoder_unit
// SENT frame encoder: one frame request in, one result per line period out.
// ----------------------------------------------------------------------------
// Usage:
//   A frame request (status_nibble, data_nibbles) is taken at a clock edge
//   where start is high and busy is low. The block then sends one result per
//   cycle on the result ports, each marked by strobe for exactly one cycle:
//   sync, status, nibble_count data nibbles, crc, optional pause, end.
//   The first result is strobed once the request has passed the state
//   register and the result register; the results follow back to back, one
//   per cycle, the sequencer stepping one period per cycle through a shared
//   nibble/crc4 unit. busy stays high from the sync period through the end
//   period, and a new request can be taken once it is low again.
//   A request while nibble_count exceeds eight is taken and dropped: no
//   results, busy stays low.
//   Configuration (wr_en, wr_index, wr_data) is to be written by the user
//   only while idle; the block itself does not enforce this. The receiver
//   cannot stall; results must be taken when strobed. Reset clears the
//   sequencer and sets nibble_count 8, pause_enable 1, idle_polarity 0.
// ----------------------------------------------------------------------------
`default_nettype none

module sent_frame_pulse_encoder_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [3:0]  status_nibble,
	input  wire logic [31:0] data_nibbles,
	input  wire logic        wr_en,
	input  wire logic [1:0]  wr_index,
	input  wire logic [3:0]  wr_data,
	output logic             strobe,
	output logic [2:0]       segment_kind,
	output logic [3:0]       nibble_value,
	output logic [5:0]       period_ticks,
	output logic [2:0]       pulse_ticks,
	output logic             pulse_level,
	output logic             last
);
	import sfpe_pkg::*;

	logic [3:0] nibble_count_q;
	logic       pause_enable_q;
	logic       idle_polarity_q;
	ctrl_t      ctrl;
	logic [3:0] value;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nibble_count_q  <= 4'd8;
			pause_enable_q  <= 1'b1;
			idle_polarity_q <= 1'b0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_NIBBLE_COUNT:  nibble_count_q  <= wr_data;
				REG_PAUSE_ENABLE:  pause_enable_q  <= wr_data[0];
				REG_IDLE_POLARITY: idle_polarity_q <= wr_data[0];
				default: ;
			endcase
		end
	end

	// sequencer
	sfpe_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.nibble_count (nibble_count_q),
		.pause_enable (pause_enable_q),
		.busy         (busy),
		.ctrl         (ctrl)
	);

	// nibble and crc unit
	sfpe_nib u_nib (
		.clk           (clk),
		.ctrl          (ctrl),
		.status_nibble (status_nibble),
		.data_nibbles  (data_nibbles),
		.nibble_count  (nibble_count_q),
		.value         (value)
	);

	// period formatter and result register
	sfpe_out u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.value         (value),
		.idle_polarity (idle_polarity_q),
		.strobe        (strobe),
		.segment_kind  (segment_kind),
		.nibble_value  (nibble_value),
		.period_ticks  (period_ticks),
		.pulse_ticks   (pulse_ticks),
		.pulse_level   (pulse_level),
		.last          (last)
	);

endmodule

`default_nettype wire

@@ src/sfpe_ctrl.sv @@
// ----------------------------------------------------------------------------
// sfpe_ctrl
// Frame sequencer: walks sync, status, data, crc, pause and end periods.
// ----------------------------------------------------------------------------
`default_nettype none

module sfpe_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [3:0]   nibble_count,
	input  wire logic         pause_enable,
	output logic              busy,
	output sfpe_pkg::ctrl_t   ctrl
);
	import sfpe_pkg::*;

	state_t     state_q;
	state_t     state_d;
	logic [3:0] cnt_q;
	logic       count_ok;
	logic       accept;

	// a request is taken while idle; a frame starts only when the nibble count is in range
	assign count_ok = (nibble_count <= 4'(MAX_DATA_NIBBLES));
	assign accept   = start && (state_q == ST_IDLE);
	assign busy     = (state_q != ST_IDLE);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (start && count_ok) state_d = ST_SYNC;
			ST_SYNC:   state_d = ST_STATUS;
			ST_STATUS: state_d = (cnt_q != 4'd0) ? ST_DATA : ST_CRC;
			ST_DATA:   if (cnt_q == 4'd1) state_d = ST_CRC;
			ST_CRC:    state_d = pause_enable ? ST_PAUSE : ST_END;
			ST_PAUSE:  state_d = ST_END;
			ST_END:    state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// outputs per state
	always_comb begin
		ctrl.load = accept;
		ctrl.step = 1'b0;
		ctrl.emit = 1'b1;
		ctrl.kind = KIND_SYNC;
		unique case (state_q)
			ST_IDLE:   ctrl.emit = 1'b0;
			ST_SYNC:   ctrl.kind = KIND_SYNC;
			ST_STATUS: ctrl.kind = KIND_STATUS;
			ST_DATA: begin
				ctrl.kind = KIND_DATA;
				ctrl.step = 1'b1;
			end
			ST_CRC:    ctrl.kind = KIND_CRC;
			ST_PAUSE:  ctrl.kind = KIND_PAUSE;
			ST_END:    ctrl.kind = KIND_END;
			default:   ctrl.emit = 1'b0;
		endcase
	end

	// state and remaining data nibble count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= 4'd0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cnt_q <= nibble_count;
			end else if (state_q == ST_DATA) begin
				cnt_q <= cnt_q - 4'd1;
			end
		end
	end

`ifndef ASSERT_OFF
	a_data_has_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DATA) |-> (cnt_q != 4'd0))
		else $error("data period with no nibbles left");

	a_drop_bad_count: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !count_ok) |=> (state_q == ST_IDLE))
		else $error("frame with out-of-range count not dropped");

	a_end_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_END) |=> (state_q == ST_IDLE))
		else $error("end period not followed by idle");
`endif

endmodule

`default_nettype wire

@@ src/sfpe_nib.sv @@
// ----------------------------------------------------------------------------
// sfpe_nib
// Nibble unit: data shift register and the shared crc4 step.
// ----------------------------------------------------------------------------
`default_nettype none

module sfpe_nib (
	input  wire logic        clk,
	input  wire sfpe_pkg::ctrl_t ctrl,
	input  wire logic [3:0]  status_nibble,
	input  wire logic [31:0] data_nibbles,
	input  wire logic [3:0]  nibble_count,
	output logic [3:0]       value
);
	import sfpe_pkg::*;

	logic [31:0] data_q;
	logic [3:0]  status_q;
	logic [3:0]  crc_q;

	// load on request, shift one nibble and step the crc per data period
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			data_q   <= data_nibbles;
			status_q <= status_nibble;
			crc_q    <= (nibble_count != 4'd0) ? CRC_SEED : 4'd0;
		end else if (ctrl.step) begin
			data_q <= {4'd0, data_q[31:4]};
			crc_q  <= crc_step(crc_q, data_q[3:0]);
		end
	end

	// value coded by the current period
	always_comb begin
		case (ctrl.kind)
			KIND_STATUS: value = status_q;
			KIND_DATA:   value = data_q[3:0];
			KIND_CRC:    value = crc_q;
			default:     value = 4'd0;
		endcase
	end

endmodule

`default_nettype wire

@@ src/sfpe_out.sv @@
// ----------------------------------------------------------------------------
// sfpe_out
// Period formatter and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sfpe_out (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire sfpe_pkg::ctrl_t ctrl,
	input  wire logic [3:0]  value,
	input  wire logic        idle_polarity,
	output logic             strobe,
	output logic [2:0]       segment_kind,
	output logic [3:0]       nibble_value,
	output logic [5:0]       period_ticks,
	output logic [2:0]       pulse_ticks,
	output logic             pulse_level,
	output logic             last
);
	import sfpe_pkg::*;

	logic       strobe_q;
	logic [2:0] kind_q;
	logic [3:0] value_q;
	logic [5:0] period_q;
	logic [2:0] pulse_q;
	logic       level_q;
	logic       last_q;
	logic [5:0] period_d;

	// period length by kind
	always_comb begin
		case (ctrl.kind)
			KIND_SYNC: period_d = SYNC_TICKS;
			KIND_END:  period_d = END_TICKS;
			default:   period_d = BASE_TICKS + {2'd0, value};
		endcase
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= ctrl.emit;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (ctrl.emit) begin
			kind_q   <= ctrl.kind;
			value_q  <= value;
			period_q <= period_d;
			pulse_q  <= (ctrl.kind == KIND_END) ? END_PULSE_TICKS : PULSE_TICKS;
			level_q  <= ~idle_polarity;
			last_q   <= (ctrl.kind == KIND_END);
		end
	end

	assign strobe       = strobe_q;
	assign segment_kind = kind_q;
	assign nibble_value = value_q;
	assign period_ticks = period_q;
	assign pulse_ticks  = pulse_q;
	assign pulse_level  = level_q;
	assign last         = last_q;

`ifndef ASSERT_OFF
	a_strobe_follows_emit: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.emit |=> strobe_q)
		else $error("emitted period not strobed");

	a_last_is_short: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && last_q) |-> ((period_q == END_TICKS) && (pulse_q == END_PULSE_TICKS)))
		else $error("end period with wrong timing");

	a_sync_then_status: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.emit && (ctrl.kind == KIND_SYNC)) |=> (ctrl.emit && (ctrl.kind == KIND_STATUS)))
		else $error("sync not followed by status");
`endif

endmodule

`default_nettype wire
